/* rtl/dccgen_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dccgen_pkg - shared definitions for the dcc track signal generator
// Field widths, register indexes, reset values, frame part and phase codes.
// ----------------------------------------------------------------------------
package dccgen_pkg;

    // configuration port
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LEN = 2'd2;

    // register widths and reset values
    localparam int BYTE_COUNT_W = 3;
    localparam int PACKET_W     = 48;
    localparam int PREAMBLE_W   = 5;

    localparam logic [BYTE_COUNT_W-1:0] BYTE_COUNT_RST   = 3'd2;
    localparam logic [PACKET_W-1:0]     PACKET_BYTES_RST = 48'h2E90_0000_0000;
    localparam logic [PREAMBLE_W-1:0]   PREAMBLE_LEN_RST = 5'd14;

    // byte positions held by the packet register
    localparam int PKT_BYTES = PACKET_W / 8;

    // default maximum number of data bytes in use
    localparam int MAX_BYTES_DEF = 6;

    // stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    // frame part codes as reported
    localparam int PART_W = 3;
    localparam logic [PART_W-1:0] PART_PREAMBLE  = 3'd0;
    localparam logic [PART_W-1:0] PART_SEPARATOR = 3'd1;
    localparam logic [PART_W-1:0] PART_DATA      = 3'd2;
    localparam logic [PART_W-1:0] PART_CHECKSUM  = 3'd3;
    localparam logic [PART_W-1:0] PART_END       = 3'd4;

    // frame phase codes (unused code behaves as preamble)
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_PREAMBLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DATA     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CHECKSUM = 2'd2;

endpackage

/* rtl/dcc_track_signal_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_track_signal_generator - dcc packet bit and track level generator
// Each timer tick item advances the bit timing and yields one result item
// with the drive level, the bit on the line and its part of the frame.
// ----------------------------------------------------------------------------
// a result item is valid in the cycle after its tick item is accepted
// throughput: one item per cycle; set by the single result register, which
//   takes a new item whenever it is empty or being drained in that cycle
// reset: synchronous active-low; configuration and state registers return to their defaults, the
//   line starts low at the beginning of a preamble, no result pending
module dcc_track_signal_generator #(
    parameter int MAX_BYTES = dccgen_pkg::MAX_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick item
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [dccgen_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,   // [0] tick
    // result item
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [dccgen_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,   // [0] drive_high,
                                                                  // [1] bit_value,
                                                                  // [4:2] frame_part
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [dccgen_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dccgen_pkg::CFG_W-1:0]        i_cfg_data
);
    import dccgen_pkg::*;

    // used byte count width and bit counter width
    localparam int UW = $clog2(MAX_BYTES + 1);
    localparam int CW = (UW + 3 > PREAMBLE_W) ? UW + 3 : PREAMBLE_W;

    // configuration registers
    logic [BYTE_COUNT_W-1:0] r_byte_count;
    logic [PACKET_W-1:0]     r_packet_bytes;
    logic [PREAMBLE_W-1:0]   r_preamble_len;

    // bit generator state
    logic               r_sending, n_sending;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_stretch, n_stretch;
    logic               r_first, n_first;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_sep, n_sep;
    logic               r_level, n_level;
    logic [PART_W-1:0]  r_part, n_part;

    // result register
    logic               r_out_valid;
    logic               r_out_level;
    logic               r_out_bit;
    logic [PART_W-1:0]  r_out_part;

    logic               w_accept;
    logic               w_tick;
    logic [UW-1:0]      w_used;
    logic [CW-1:0]      w_data_len;
    logic [7:0]         w_xsum;
    logic [7:0]         w_byte;

    // handshake
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_tick          = i_s_axis_tdata[0];

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= BYTE_COUNT_RST;
            r_packet_bytes <= PACKET_BYTES_RST;
            r_preamble_len <= PREAMBLE_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BYTE_COUNT:   r_byte_count   <= i_cfg_data[BYTE_COUNT_W-1:0];
                REG_PACKET_BYTES: r_packet_bytes <= i_cfg_data[PACKET_W-1:0];
                REG_PREAMBLE_LEN: r_preamble_len <= i_cfg_data[PREAMBLE_W-1:0];
                default: ;
            endcase
        end
    end

    // data bytes in use, saturated, and data length in bits
    always_comb begin
        if (32'(r_byte_count) > MAX_BYTES) begin
            w_used = UW'(MAX_BYTES);
        end else begin
            w_used = UW'(r_byte_count);
        end
        w_data_len = CW'({w_used, 3'b000});
    end

    // checksum over the bytes in use
    always_comb begin
        w_xsum = 8'h00;
        for (int i = 0; i < PKT_BYTES; i++) begin
            if (i < 32'(w_used)) begin
                w_xsum = w_xsum ^ r_packet_bytes[PACKET_W-1-8*i -: 8];
            end
        end
    end

    // bit timing and frame sequencing for one tick
    always_comb begin
        logic [PHASE_W-1:0] v_phase;
        logic [CW-1:0]      v_cnt;
        logic               v_start;
        logic               v_bit;
        logic [PART_W-1:0]  v_part;

        n_sending = r_sending;
        n_cnt     = r_cnt;
        n_stretch = r_stretch;
        n_first   = r_first;
        n_phase   = r_phase;
        n_sep     = r_sep;
        n_level   = r_level;
        n_part    = r_part;
        v_phase   = r_phase;
        v_cnt     = r_cnt;
        v_start   = 1'b0;
        v_bit     = 1'b1;
        v_part    = PART_PREAMBLE;
        w_byte    = 8'h00;

        // byte under the counter, zero past the register
        for (int i = 0; i < PKT_BYTES; i++) begin
            if (32'(r_cnt[CW-1:3]) == i) begin
                w_byte = r_packet_bytes[PACKET_W-1-8*i -: 8];
            end
        end

        if (w_tick) begin
            if (!r_sending && !r_stretch) begin
                // zero-bit halves last one extra tick
                n_stretch = 1'b1;
            end else begin
                n_stretch = 1'b0;
                if (r_first) begin
                    n_first = 1'b0;
                    n_level = 1'b0;
                end else begin
                    // preamble ones
                    if (v_phase != PH_DATA && v_phase != PH_CHECKSUM) begin
                        if (v_cnt < CW'(r_preamble_len)) begin
                            v_cnt   = v_cnt + 1'b1;
                            v_start = 1'b1;
                            v_bit   = 1'b1;
                            v_part  = PART_PREAMBLE;
                        end else begin
                            v_cnt   = '0;
                            v_phase = PH_DATA;
                        end
                    end
                    // separators and data bits
                    if (!v_start && v_phase == PH_DATA) begin
                        if (v_cnt[2:0] == 3'd0 && !r_sep) begin
                            n_sep   = 1'b1;
                            v_start = 1'b1;
                            v_bit   = 1'b0;
                            v_part  = PART_SEPARATOR;
                        end else begin
                            n_sep = 1'b0;
                            if (v_cnt < w_data_len) begin
                                v_bit   = w_byte[~v_cnt[2:0]];
                                v_cnt   = v_cnt + 1'b1;
                                v_start = 1'b1;
                                v_part  = PART_DATA;
                            end else begin
                                v_cnt   = '0;
                                v_phase = PH_CHECKSUM;
                            end
                        end
                    end
                    // checksum bits, then the closing one
                    if (!v_start) begin
                        if (v_cnt < CW'(8)) begin
                            v_bit   = w_xsum[~v_cnt[2:0]];
                            v_cnt   = v_cnt + 1'b1;
                            v_start = 1'b1;
                            v_part  = PART_CHECKSUM;
                        end else begin
                            v_phase = PH_PREAMBLE;
                            v_cnt   = CW'(1);
                            v_start = 1'b1;
                            v_bit   = 1'b1;
                            v_part  = PART_END;
                        end
                    end
                    n_phase   = v_phase;
                    n_cnt     = v_cnt;
                    n_sending = v_bit;
                    n_level   = 1'b1;
                    n_first   = 1'b1;
                    n_part    = v_part;
                end
            end
        end
    end

    // state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending <= 1'b1;
            r_cnt     <= '0;
            r_stretch <= 1'b0;
            r_first   <= 1'b1;
            r_phase   <= PH_PREAMBLE;
            r_sep     <= 1'b0;
            r_level   <= 1'b0;
            r_part    <= PART_PREAMBLE;
        end else if (w_accept) begin
            r_sending <= n_sending;
            r_cnt     <= n_cnt;
            r_stretch <= n_stretch;
            r_first   <= n_first;
            r_phase   <= n_phase;
            r_sep     <= n_sep;
            r_level   <= n_level;
            r_part    <= n_part;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_level <= n_level;
            r_out_bit   <= n_sending;
            r_out_part  <= n_part;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - PART_W - 2)'(0), r_out_part, r_out_bit,
                              r_out_level};

endmodule
